>>> src/attention_context_accumulator_assert.svh
// Assertion macros for the context accumulator checkers.
`ifndef ATTENTION_CONTEXT_ACCUMULATOR_ASSERT_SVH
`define ATTENTION_CONTEXT_ACCUMULATOR_ASSERT_SVH

// Clocked assertion, switched off while reset is high.
`define ACA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define ACA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/attn_ctx_pkg.sv
// Shared types and constants of the attention context accumulator.
package attn_ctx_pkg;

  localparam int HEAD_DIM_W = 9;
  localparam logic [HEAD_DIM_W-1:0] HEAD_DIM_RESET = 9'd128;
  localparam int OPERAND_W = 16;
  localparam int CTX_W = 32;
  localparam int SCALE_W = 32;
  localparam int SHIFT_W = 5;
  localparam int INDEX_W = 8;
  localparam int PROD_W = 2 * CTX_W;

  typedef enum logic [1:0] {
    OP_ACCUM   = 2'd0,
    OP_LOAD    = 2'd1,
    OP_RESCALE = 2'd2,
    OP_READ    = 2'd3
  } op_t;

endpackage

>>> src/attention_context_accumulator.sv
// Context vector accumulator: read-modify-write pipeline around one context memory.
//
// Input channel item_valid/item_stall carries opcode, weight, value, norm_mult and
// norm_shift; each transaction works on the entry at the current position, which
// then advances and wraps at row_len. Output channel result_valid/result_stall
// carries context_value, entry_index and row_last, one transaction per input.
// The user must write row_len via cfg_we/cfg_wdata only while idle; not enforced.
//
// An accepted item passes the stage 1 and stage 2 registers into the output register.
// Throughput: one item per cycle when row_len is 3 or more and no result stalls.
// The memory write lands at the end of stage 2, so an item whose entry is still
// being updated waits: with row_len 1 each item waits for the write of the one
// before it, with row_len 2 for the write of the one two items before it.
// Reset (rst, synchronous) clears position, row_len to 128 and the fill count;
// entries at or above the fill count read as zero, so no clearing pass is run.
// item_stall is high during reset.
// A stalled result holds in the output register; the pipeline stages behind it
// keep filling until full, then item_stall rises.
module attention_context_accumulator
  import attn_ctx_pkg::*;
#(
  parameter int MAX_HEAD_DIM = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [HEAD_DIM_W-1:0]       cfg_wdata,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [1:0]                  opcode,
  input  logic signed [OPERAND_W-1:0] weight,
  input  logic signed [OPERAND_W-1:0] value,
  input  logic signed [SCALE_W-1:0]   norm_mult,
  input  logic [SHIFT_W-1:0]          norm_shift,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic signed [CTX_W-1:0]     context_value,
  output logic [INDEX_W-1:0]          entry_index,
  output logic                        row_last
);

  localparam int IDX_W = $clog2(MAX_HEAD_DIM);
  localparam int CNT_W = IDX_W + 1;
  localparam int CMP_W = (CNT_W > HEAD_DIM_W) ? CNT_W : HEAD_DIM_W;
  localparam int EXT_W = IDX_W + INDEX_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_HEAD_DIM);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_HEAD_DIM);

  // Configuration and walk state
  logic [HEAD_DIM_W-1:0] row_len;
  logic [IDX_W-1:0]      position;
  logic [CNT_W-1:0]      fill;
  logic [CMP_W-1:0]      hd_ext;
  logic [CNT_W-1:0]      dim;
  logic [IDX_W-1:0]      idx;
  logic [CNT_W-1:0]      idx_inc;
  logic                  idx_last;
  logic                  hazard;
  logic                  accept;
  logic signed [CTX_W-1:0] prod_in;

  // Stage 1: memory read data arrives
  logic                    v1;
  op_t                     s1_op;
  logic signed [CTX_W-1:0] s1_prod;
  logic signed [SCALE_W-1:0] s1_num;
  logic [SHIFT_W-1:0]      s1_shift;
  logic [IDX_W-1:0]        s1_idx;
  logic                    s1_last;
  logic                    s1_hit;
  logic [CTX_W-1:0]        rdata;
  logic signed [CTX_W-1:0] s1_entry;
  logic signed [CTX_W-1:0] s1_res;
  logic signed [PROD_W-1:0] s1_mul;

  // Stage 2: rounding shift, write back
  logic                     v2;
  logic                     s2_rescale;
  logic signed [CTX_W-1:0]  s2_res;
  logic signed [PROD_W-1:0] s2_mul;
  logic [SHIFT_W-1:0]       s2_shift;
  logic [IDX_W-1:0]         s2_idx;
  logic                     s2_last;
  logic signed [PROD_W-1:0] half;
  logic signed [PROD_W-1:0] rounded;
  logic signed [PROD_W-1:0] shifted;
  logic signed [CTX_W-1:0]  s2_result;
  logic [EXT_W-1:0]         s2_idx_ext;
  logic                     wr_en;

  logic ready1;
  logic ready2;
  logic ready3;

  logic [CTX_W-1:0] store [MAX_HEAD_DIM];

  always_ff @(posedge clk) begin
    if (rst) begin
      row_len <= HEAD_DIM_RESET;
    end else if (cfg_we) begin
      row_len <= cfg_wdata;
    end
  end

  // Entries in use: zero counts as one, clamp at the store depth
  always_comb begin
    hd_ext = CMP_W'(row_len);
    if (hd_ext == '0) begin
      dim = CNT_W'(1);
    end else if (hd_ext > MAX_CMP) begin
      dim = MAX_CNT;
    end else begin
      dim = CNT_W'(hd_ext);
    end
  end

  always_comb begin
    idx      = (CNT_W'(position) < dim) ? position : '0;
    idx_inc  = CNT_W'(idx) + CNT_W'(1);
    idx_last = (idx_inc == dim);
  end

  assign ready3 = !result_valid || !result_stall;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;

  // Interlock on an entry whose write has not landed yet
  assign hazard     = (v1 && (s1_idx == idx)) || (v2 && (s2_idx == idx));
  assign item_stall = rst || !ready1 || hazard;
  assign accept     = item_valid && !item_stall;

  assign prod_in = CTX_W'(weight) * CTX_W'(value);

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (accept) begin
      position <= idx_last ? '0 : idx_inc[IDX_W-1:0];
    end
  end

  // Entries are always touched in walk order from 0, so the written ones form
  // a prefix; anything at or above fill is read as zero whatever the memory holds.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (wr_en && (CNT_W'(s2_idx) == fill)) begin
      fill <= fill + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[s2_idx] <= s2_result;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= store[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= op_t'(opcode);
      s1_prod  <= prod_in;
      s1_num   <= norm_mult;
      s1_shift <= norm_shift;
      s1_idx   <= idx;
      s1_last  <= idx_last;
      s1_hit   <= (CNT_W'(idx) < fill);
    end
  end

  always_comb begin
    s1_entry = s1_hit ? $signed(rdata) : '0;
    s1_mul   = PROD_W'(s1_entry) * PROD_W'(s1_num);
    case (s1_op)
      OP_ACCUM: s1_res = s1_entry + s1_prod;
      OP_LOAD:  s1_res = s1_prod;
      default:  s1_res = s1_entry;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      s2_rescale <= (s1_op == OP_RESCALE);
      s2_res     <= s1_res;
      s2_mul     <= s1_mul;
      s2_shift   <= s1_shift;
      s2_idx     <= s1_idx;
      s2_last    <= s1_last;
    end
  end

  // Add half if non-negative, else subtract it; then arithmetic shift
  always_comb begin
    half      = (PROD_W'(1) << s2_shift) >>> 1;
    rounded   = s2_mul[PROD_W-1] ? (s2_mul - half) : (s2_mul + half);
    shifted   = rounded >>> s2_shift;
    s2_result = s2_rescale ? shifted[CTX_W-1:0] : s2_res;
  end

  assign wr_en      = v2 && ready3;
  assign s2_idx_ext = EXT_W'(s2_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready3) begin
      result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      context_value <= s2_result;
      entry_index   <= s2_idx_ext[INDEX_W-1:0];
      row_last      <= s2_last;
    end
  end

endmodule

>>> src/attn_ctx_checker.sv
// Port-level checker for the attention context accumulator, with its bind.
`include "attention_context_accumulator_assert.svh"

module attn_ctx_checker
  import attn_ctx_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic [CTX_W-1:0]   context_value,
  input logic [INDEX_W-1:0] entry_index,
  input logic               row_last
);

  `ACA_ASSERT(a_result_held, (result_valid && result_stall |=> result_valid), "result dropped while stalled")
  `ACA_ASSERT(a_payload_held, (result_valid && result_stall |=> $stable(context_value) && $stable(entry_index) && $stable(row_last)), "stalled result payload changed")
  // A fresh result on an idle output comes from an item taken in via stages 1 and 2
  `ACA_ASSERT(a_result_latency, ($rose(result_valid) |-> $past(item_valid && !item_stall, 3)), "result without a matching input transaction")
  `ACA_ASSERT_ALWAYS(a_reset_clears, (rst |=> !result_valid && item_stall == rst), "output not cleared by reset")

endmodule

bind attention_context_accumulator attn_ctx_checker u_attn_ctx_checker (.*);

>>> tb/sv/ctx_accum_monitor.sv
`timescale 1ns / 1ps
// Channel monitor for the context accumulator: tracks the context vector, predicts and compares results.
module ctx_accum_monitor
  import attn_ctx_pkg::*;
#(
  parameter int MAX_HEAD_DIM = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [HEAD_DIM_W-1:0]       cfg_wdata,
  input  logic                        item_valid,
  input  logic                        item_stall,
  input  logic [1:0]                  opcode,
  input  logic signed [OPERAND_W-1:0] weight,
  input  logic signed [OPERAND_W-1:0] value,
  input  logic signed [SCALE_W-1:0]   norm_mult,
  input  logic [SHIFT_W-1:0]          norm_shift,
  input  logic                        result_valid,
  input  logic                        result_stall,
  input  logic signed [CTX_W-1:0]     context_value,
  input  logic [INDEX_W-1:0]          entry_index,
  input  logic                        row_last,
  output int                          mismatch_count,
  output int                          pending_count
);

  typedef struct packed {
    logic [CTX_W-1:0]   context_value;
    logic [INDEX_W-1:0] entry_index;
    logic               row_last;
  } entry_result_t;

  logic [CTX_W-1:0]      ctx_mem [MAX_HEAD_DIM];
  int unsigned           walk_pos;
  logic [HEAD_DIM_W-1:0] dim_reg;
  entry_result_t         expected_entries[$];
  int                    mismatch_total = 0;

  assign mismatch_count = mismatch_total;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_total++;
  endtask

  task automatic apply_context_op(input op_t op, input logic signed [OPERAND_W-1:0] w,
                                  input logic signed [OPERAND_W-1:0] v,
                                  input logic signed [SCALE_W-1:0] num,
                                  input logic [SHIFT_W-1:0] sh);
    int unsigned             rows;
    int unsigned             idx;
    logic signed [CTX_W-1:0] prod;
    logic signed [PROD_W-1:0] wide;
    logic signed [PROD_W-1:0] half;
    entry_result_t           r;
    rows = (dim_reg == '0) ? 1 : ((dim_reg > MAX_HEAD_DIM) ? MAX_HEAD_DIM : dim_reg);
    // a position left past the end by a shorter row restarts at entry 0
    idx = (walk_pos < rows) ? walk_pos : 0;
    prod = w * v;
    case (op)
      OP_ACCUM: ctx_mem[idx] = ctx_mem[idx] + prod;
      OP_LOAD:  ctx_mem[idx] = prod;
      OP_RESCALE: begin
        wide = $signed(ctx_mem[idx]) * num;
        half = 64'sd0;
        if (sh != '0) half = 64'sd1 << (sh - 5'd1);
        // add half if non-negative, else subtract it; then arithmetic shift
        if (wide >= 0) wide = (wide + half) >>> sh;
        else wide = (wide - half) >>> sh;
        ctx_mem[idx] = wide[CTX_W-1:0];
      end
      default: ;
    endcase
    r.context_value = ctx_mem[idx];
    r.entry_index   = idx[INDEX_W-1:0];
    r.row_last      = (idx == rows - 1);
    expected_entries.push_back(r);
    walk_pos = (idx + 1 >= rows) ? 0 : idx + 1;
  endtask

  task automatic check_result();
    entry_result_t exp_r;
    if (expected_entries.size() == 0) begin
      report_mismatch($sformatf("result with no transaction pending, index %0d", entry_index));
    end else begin
      exp_r = expected_entries.pop_front();
      if (context_value !== exp_r.context_value)
        report_mismatch($sformatf("entry %0d context_value %h, expected %h",
                                  exp_r.entry_index, context_value, exp_r.context_value));
      if (entry_index !== exp_r.entry_index)
        report_mismatch($sformatf("entry_index %0d, expected %0d",
                                  entry_index, exp_r.entry_index));
      if (row_last !== exp_r.row_last)
        report_mismatch($sformatf("entry %0d row_last %b, expected %b",
                                  exp_r.entry_index, row_last, exp_r.row_last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (ctx_mem[i]) ctx_mem[i] = '0;
      walk_pos = 0;
      dim_reg  = HEAD_DIM_RESET;
      expected_entries.delete();
    end else begin
      if (cfg_we) dim_reg = cfg_wdata;
      if (result_valid && !result_stall) check_result();
      if (item_valid && !item_stall)
        apply_context_op(op_t'(opcode), weight, value, norm_mult, norm_shift);
    end
    pending_count <= expected_entries.size();
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the context accumulator: clock, reset, stimulus, watchdog and verdict.
module testbench;
  import attn_ctx_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 72;
  localparam int MAX_ROWS = 256;
  localparam logic signed [OPERAND_W-1:0] OPND_MIN = 16'sh8000;
  localparam logic signed [OPERAND_W-1:0] OPND_MAX = 16'sh7fff;
  localparam logic signed [SCALE_W-1:0]   SCALE_MIN = 32'sh8000_0000;
  localparam logic signed [SCALE_W-1:0]   SCALE_MAX = 32'sh7fff_ffff;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [HEAD_DIM_W-1:0]       cfg_wdata = '0;
  logic                        item_valid = 1'b0;
  logic                        item_stall;
  logic [1:0]                  opcode = '0;
  logic signed [OPERAND_W-1:0] weight = '0;
  logic signed [OPERAND_W-1:0] value = '0;
  logic signed [SCALE_W-1:0]   norm_mult = '0;
  logic [SHIFT_W-1:0]          norm_shift = '0;
  logic                        result_valid;
  logic                        result_stall = 1'b0;
  logic signed [CTX_W-1:0]     context_value;
  logic [INDEX_W-1:0]          entry_index;
  logic                        row_last;

  int mismatch_count;
  int in_flight;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  attention_context_accumulator u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .item_valid(item_valid), .item_stall(item_stall), .opcode(opcode),
    .weight(weight), .value(value), .norm_mult(norm_mult), .norm_shift(norm_shift),
    .result_valid(result_valid), .result_stall(result_stall),
    .context_value(context_value), .entry_index(entry_index), .row_last(row_last)
  );

  ctx_accum_monitor u_monitor (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .item_valid(item_valid), .item_stall(item_stall), .opcode(opcode),
    .weight(weight), .value(value), .norm_mult(norm_mult), .norm_shift(norm_shift),
    .result_valid(result_valid), .result_stall(result_stall),
    .context_value(context_value), .entry_index(entry_index), .row_last(row_last),
    .mismatch_count(mismatch_count), .pending_count(in_flight)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [OPERAND_W-1:0] rand_operand();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return OPND_MIN;
      1: return OPND_MAX;
      2: return '0;
      default: return r[OPERAND_W-1:0];
    endcase
  endfunction

  function automatic logic signed [SCALE_W-1:0] rand_scale();
    logic signed [SCALE_W-1:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return SCALE_MIN;
      1: return SCALE_MAX;
      2, 3, 4: return $signed($urandom_range(0, 8)) - 32'sd4;
      default: return r;
    endcase
  endfunction

  function automatic logic [SHIFT_W-1:0] rand_shift();
    logic [31:0] r;
    r = $urandom;
    return r[SHIFT_W-1:0];
  endfunction

  function automatic op_t rand_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return OP_ACCUM;
    else if (r < 60) return OP_LOAD;
    else if (r < 80) return OP_RESCALE;
    else return OP_READ;
  endfunction

  task automatic set_idling(input int gap_pct, input int stall_pct);
    send_gap_pct = gap_pct;
    recv_stall_pct <= stall_pct;
  endtask

  task automatic send_item(input op_t op, input logic signed [OPERAND_W-1:0] w,
                           input logic signed [OPERAND_W-1:0] v,
                           input logic signed [SCALE_W-1:0] num,
                           input logic [SHIFT_W-1:0] sh);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode     <= op;
    weight     <= w;
    value      <= v;
    norm_mult  <= num;
    norm_shift <= sh;
    do @(posedge clk); while (item_stall);
  endtask

  // hold off the sender until every result has come back, then let the pipe settle
  task automatic wait_idle();
    item_valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_row_len(input logic [HEAD_DIM_W-1:0] dim);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= dim;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // row passes with one operation each, mixed with stray transactions
  task automatic run_phase(input logic [HEAD_DIM_W-1:0] dim, input int n_items);
    int          rows;
    int          sent;
    int          pass_len;
    op_t         pass_op;
    logic signed [SCALE_W-1:0] pass_num;
    logic [SHIFT_W-1:0]        pass_sh;
    write_row_len(dim);
    rows = (dim == '0) ? 1 : ((dim > MAX_ROWS) ? MAX_ROWS : dim);
    sent = 0;
    while (sent < n_items) begin
      pass_op  = rand_op();
      pass_num = rand_scale();
      pass_sh  = rand_shift();
      pass_len = $urandom_range(1, (rows < 40) ? rows : 40);
      for (int k = 0; k < pass_len && sent < n_items; k++) begin
        if (sent == n_items / 2) wait_idle();
        if ($urandom_range(0, 99) < 15)
          send_item(rand_op(), rand_operand(), rand_operand(), rand_scale(), rand_shift());
        else
          send_item(pass_op, rand_operand(), rand_operand(), pass_num, pass_sh);
        sent++;
      end
    end
  endtask

  initial begin
    logic [HEAD_DIM_W-1:0] dims [9];
    dims = '{9'd511, 9'd256, 9'd1, 9'd2, 9'd0, 9'd3, 9'd300, 9'd37, 9'd128};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(36, 50);
    // untouched entries under the reset row length
    send_item(OP_READ, '0, '0, '0, '0);
    send_item(OP_ACCUM, OPND_MAX, OPND_MAX, '0, '0);
    send_item(OP_RESCALE, '0, '0, SCALE_MAX, 5'd31);
    // zero row length acts as one entry; position 3 is now past the end
    write_row_len(9'd0);
    send_item(OP_LOAD, OPND_MIN, OPND_MIN, '0, '0);
    send_item(OP_ACCUM, OPND_MIN, OPND_MIN, '0, '0);
    send_item(OP_ACCUM, OPND_MAX, OPND_MIN, '0, '0);
    send_item(OP_RESCALE, '0, '0, SCALE_MIN, 5'd31);
    send_item(OP_RESCALE, '0, '0, SCALE_MAX, 5'd0);
    send_item(OP_LOAD, OPND_MAX, OPND_MAX, '0, '0);
    send_item(OP_RESCALE, '0, '0, 32'sd1, 5'd0);
    send_item(OP_RESCALE, '0, '0, 32'sd3, 5'd1);
    send_item(OP_LOAD, -16'sd1, 16'sd3, '0, '0);
    send_item(OP_RESCALE, '0, '0, 32'sd1, 5'd1);
    send_item(OP_RESCALE, '0, '0, -32'sd1, 5'd31);
    send_item(OP_RESCALE, OPND_MAX, OPND_MIN, 32'sd0, 5'd5);
    send_item(OP_READ, OPND_MIN, OPND_MAX, SCALE_MIN, 5'd31);
    write_row_len(9'd4);
    for (int i = 0; i < 5; i++) send_item(OP_ACCUM, OPND_MIN, OPND_MAX, '0, '0);

    for (int p = 0; p < 9; p++) begin
      if (p < 3) set_idling(36, 50);
      else if (p < 6) set_idling(50, 36);
      else set_idling(0, 0);
      run_phase(dims[p], PHASE_ITEMS);
    end

    wait_idle();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
